// ----- hdl/bgc_pkg.sv -----
// shared types and codes for the button gesture classifier
package bgc_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned CLICK_W = 2;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KEY_PWR      = 2'd0,
    KEY_VOL_UP   = 2'd1,
    KEY_VOL_DOWN = 2'd2,
    KEY_OTHER    = 2'd3
  } key_code_t;

  typedef enum logic [1:0] {
    VAL_RELEASE = 2'd0,
    VAL_PRESS   = 2'd1,
    VAL_REPEAT  = 2'd2,
    VAL_SPARE   = 2'd3
  } key_value_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_LONG   = 2'd1,
    GEST_SINGLE = 2'd2,
    GEST_DOUBLE = 2'd3
  } gesture_t;

  localparam logic [1:0] VOL_IDLE = 2'b00;
  localparam logic [1:0] VOL_UP   = 2'b01;
  localparam logic [1:0] VOL_DOWN = 2'b11;

  localparam logic [CLICK_W-1:0] CLICK_MAX = 2'd3;
  localparam logic [TICK_W-1:0]  TICK_MAX  = 16'hFFFF;

  localparam logic [TICK_W-1:0] SHORT_RESET = 16'd350;
  localparam logic [TICK_W-1:0] LONG_RESET  = 16'd900;

  localparam logic CFG_SHORT = 1'b0;
  localparam logic CFG_LONG  = 1'b1;

  typedef struct packed {
    logic               button_held;
    logic               long_reported;
    logic [CLICK_W-1:0] click_count;
    logic [TICK_W-1:0]  hold_ticks;
    logic [TICK_W-1:0]  silence_ticks;
    logic [1:0]         vol_state;
  } bgc_state_t;

  localparam bgc_state_t STATE_RESET = '{
    button_held:   1'b0,
    long_reported: 1'b0,
    click_count:   '0,
    hold_ticks:    '0,
    silence_ticks: '0,
    vol_state:     VOL_IDLE
  };

endpackage

// ----- hdl/bgc_core.sv -----
// next-state and gesture logic for one tick or key event
module bgc_core
  import bgc_pkg::*;
(
  input  bgc_state_t        st,
  input  logic              operation,
  input  logic [1:0]        key_code,
  input  logic [1:0]        key_value,
  input  logic [TICK_W-1:0] short_window_ms,
  input  logic [TICK_W-1:0] long_hold_ms,
  output bgc_state_t        st_nxt,
  output logic [1:0]        gesture
);

  logic [TICK_W-1:0] hold_inc;
  logic [TICK_W-1:0] silence_inc;

  assign hold_inc    = (st.hold_ticks == TICK_MAX) ? st.hold_ticks : st.hold_ticks + 1'b1;
  assign silence_inc = (st.silence_ticks == TICK_MAX) ? st.silence_ticks
                                                      : st.silence_ticks + 1'b1;

  always_comb begin
    st_nxt  = st;
    gesture = GEST_NONE;
    if (operation == OP_TICK) begin
      if (st.button_held) begin
        st_nxt.hold_ticks = hold_inc;
        if (!st.long_reported && hold_inc >= long_hold_ms) begin
          st_nxt.long_reported = 1'b1;
          st_nxt.click_count   = '0;
          gesture              = GEST_LONG;
        end
      end else begin
        st_nxt.silence_ticks = silence_inc;
        if (st.click_count != '0 && silence_inc >= short_window_ms) begin
          gesture            = (st.click_count >= 2'd2) ? GEST_DOUBLE : GEST_SINGLE;
          st_nxt.click_count = '0;
        end
      end
    end else begin
      unique case (key_code)
        KEY_PWR: begin
          if (key_value == VAL_PRESS) begin
            st_nxt.button_held   = 1'b1;
            st_nxt.hold_ticks    = '0;
            st_nxt.long_reported = 1'b0;
          end else if (key_value == VAL_RELEASE) begin
            st_nxt.button_held   = 1'b0;
            st_nxt.silence_ticks = '0;
            if (!st.long_reported && st.click_count != CLICK_MAX) begin
              st_nxt.click_count = st.click_count + 1'b1;
            end
          end
        end
        KEY_VOL_UP: begin
          if (key_value != VAL_RELEASE) begin
            st_nxt.vol_state = VOL_UP;
          end else if (st.vol_state == VOL_UP) begin
            st_nxt.vol_state = VOL_IDLE;
          end
        end
        KEY_VOL_DOWN: begin
          if (key_value != VAL_RELEASE) begin
            st_nxt.vol_state = VOL_DOWN;
          end else if (st.vol_state == VOL_DOWN) begin
            st_nxt.vol_state = VOL_IDLE;
          end
        end
        default: begin
          st_nxt = st;
        end
      endcase
    end
  end

endmodule

// ----- hdl/button_gesture_classifier_unit.sv -----
// top level of the button gesture classifier
//
//   channel  ports                                           direction
//   in       in_valid in_stall in_operation in_key_code      input items
//            in_key_value
//   out      out_valid out_stall out_gesture                 result items
//            out_volume_direction
//   cfg      cfg_wr_en cfg_index cfg_data                    register writes
//
// one item per cycle while the output is not stalled; an input transfer reaches the
// result through the input register, then the state update into the result register
// one item may sit in the input register while a result waits to be taken
// synchronous reset clears state, registers go to 350 and 900 ticks
module button_gesture_classifier_unit
  import bgc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [1:0]        in_key_code,
  input  logic [1:0]        in_key_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_gesture,
  output logic signed [1:0] out_volume_direction,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [TICK_W-1:0] cfg_data
);

  logic              s1_valid_r;
  logic              s1_op_r;
  logic [1:0]        s1_code_r;
  logic [1:0]        s1_value_r;
  logic              out_valid_r;
  logic [1:0]        gesture_r;
  logic [1:0]        vol_r;
  logic [TICK_W-1:0] short_r;
  logic [TICK_W-1:0] long_r;
  bgc_state_t        st_r;
  bgc_state_t        st_nxt;
  logic [1:0]        gesture_nxt;
  logic              out_free;
  logic              load;
  logic              in_xfer;

  assign out_free = !out_valid_r || !out_stall;
  assign load     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  bgc_core u_core (
    .st              (st_r),
    .operation       (s1_op_r),
    .key_code        (s1_code_r),
    .key_value       (s1_value_r),
    .short_window_ms (short_r),
    .long_hold_ms    (long_r),
    .st_nxt          (st_nxt),
    .gesture         (gesture_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= SHORT_RESET;
      long_r  <= LONG_RESET;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_SHORT) begin
        short_r <= cfg_data;
      end else begin
        long_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (load) begin
        s1_valid_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r    <= in_operation;
      s1_code_r  <= in_key_code;
      s1_value_r <= in_key_value;
    end
    if (load) begin
      gesture_r <= gesture_nxt;
      vol_r     <= st_nxt.vol_state;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_gesture          = gesture_r;
  assign out_volume_direction = vol_r;

  a_long_marks: assert property (@(posedge clk) disable iff (!rst_n)
    load && gesture_nxt == GEST_LONG |=> st_r.long_reported && st_r.click_count == '0)
    else $error("long press without marking the hold");

  a_click_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && (gesture_nxt == GEST_SINGLE || gesture_nxt == GEST_DOUBLE)
    |=> st_r.click_count == '0 && !st_r.button_held)
    else $error("click gesture left clicks pending");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(st_r))
    else $error("state changed without a transfer");

  a_vol_code: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.vol_state != 2'b10)
    else $error("volume state holds an unused code");

endmodule
